// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros shared by the time bank modules.
// Each macro expands to one labeled concurrent assertion that is checked on
// the rising clock edge and switched off while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define FTA_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// A condition that must be followed in the next cycle by another.
`define FTA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/fta_pkg.sv =====
// ----------------------------------------------------------------------------
// fta_pkg
// Types and constants shared by the fixed timestep accumulator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package fta_pkg;

    localparam int STEP_W    = 20;
    localparam int CAP_W     = 8;
    localparam int FT_W      = 24;
    localparam int ALPHA_W   = 17;
    localparam int FRAC_BITS = 16;
    localparam int CNT32_W   = 32;
    localparam int ADDR_W    = 3;
    localparam int DATA_W    = 32;

    localparam logic [STEP_W-1:0]  STEP_MIN      = 20'd1000;
    localparam logic [STEP_W-1:0]  STEP_MAX      = 20'd1000000;
    localparam logic [STEP_W-1:0]  STEP_RESET    = 20'd16667;
    localparam logic [CAP_W-1:0]   CAP_RESET     = 8'd5;
    localparam logic [CAP_W-1:0]   CAP_ONE       = 8'd1;
    localparam logic [ALPHA_W-1:0] ALPHA_ONE     = 17'h10000;
    localparam logic [CNT32_W-1:0] CNT32_MAX     = 32'hFFFF_FFFF;

    // Item kinds.
    localparam logic KIND_FRAME = 1'b0;
    localparam logic KIND_STEP  = 1'b1;

    // Register index, taken from address bit 2.
    localparam logic REG_STEP_LENGTH = 1'b0;
    localparam logic REG_MAX_STEPS   = 1'b1;

    typedef struct packed {
        logic            kind;
        logic [FT_W-1:0] frame_time;
    } in_word_t;

    typedef struct packed {
        logic               step_taken;
        logic [ALPHA_W-1:0] alpha;
        logic [CAP_W-1:0]   frame_steps;
        logic [CNT32_W-1:0] dropped_time;
        logic [CNT32_W-1:0] step_total;
    } out_word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_APPLY,
        ST_MOD,
        ST_COMMIT,
        ST_CHECK,
        ST_FRAC,
        ST_DONE
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic apply;
        logic mod_start;
        logic mod_commit;
        logic frac_start;
        logic div_step;
        logic alpha_one;
        logic out_load;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic kind_step;
        logic bank_ge_step;
        logic cap_hit;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== sv/fta_ctrl.sv =====
// ----------------------------------------------------------------------------
// fta_ctrl
// Sequencer that walks one word through update, remainder and alpha division.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module fta_ctrl
    import fta_pkg::*;
#(
    parameter int TIME_WIDTH = 32
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     item_valid,
    output logic          item_stall,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd
);

    localparam int CNT_W = $clog2(TIME_WIDTH);
    localparam logic [CNT_W-1:0] MOD_LAST  = CNT_W'(TIME_WIDTH - 1);
    localparam logic [CNT_W-1:0] FRAC_LAST = CNT_W'(FRAC_BITS - 1);

    ctrl_state_t      state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             drop_case;

    assign drop_case = stat.kind_step && stat.bank_ge_step && stat.cap_hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Next state and iteration count.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                if (drop_case)
                begin
                    state_next = ST_MOD;
                    cnt_next   = MOD_LAST;
                end
                else
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_MOD:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = ST_COMMIT;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_COMMIT:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (stat.bank_ge_step)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_FRAC;
                    cnt_next   = FRAC_LAST;
                end
            end
            ST_FRAC:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Commands.
    always_comb
    begin
        cmd        = '0;
        item_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                item_stall  = 1'b0;
                cmd.capture = item_valid;
            end
            ST_APPLY:
            begin
                cmd.mod_start = drop_case;
                cmd.apply     = !drop_case;
            end
            ST_MOD:
            begin
                cmd.div_step = 1'b1;
            end
            ST_COMMIT:
            begin
                cmd.mod_commit = 1'b1;
            end
            ST_CHECK:
            begin
                cmd.alpha_one  = stat.bank_ge_step;
                cmd.frac_start = !stat.bank_ge_step;
            end
            ST_FRAC:
            begin
                cmd.div_step = 1'b1;
            end
            ST_DONE:
            begin
                cmd.out_load = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    `FTA_ASSERT(a_one_div_cmd, clk, rst_n,
        $onehot0({cmd.apply, cmd.mod_start, cmd.mod_commit, cmd.frac_start, cmd.div_step}),
        "divider commands overlap")
    `FTA_ASSERT_NEXT(a_capture_goes_apply, clk, rst_n, cmd.capture,
        state_reg == ST_APPLY, "captured word did not reach the update state")
    `FTA_ASSERT_NEXT(a_frac_end_done, clk, rst_n,
        (state_reg == ST_FRAC) && (cnt_reg == '0), state_reg == ST_DONE,
        "alpha division did not finish after sixteen steps")

endmodule

`default_nettype wire

// ===== sv/fta_dp.sv =====
// ----------------------------------------------------------------------------
// fta_dp
// Time bank, frame counters, shared restoring divider and result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module fta_dp
    import fta_pkg::*;
#(
    parameter int TIME_WIDTH = 32
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire in_word_t          item,
    input  wire logic [STEP_W-1:0] step_eff,
    input  wire logic [CAP_W-1:0]  cap_eff,
    input  wire dp_cmd_t           cmd,
    output dp_stat_t               stat,
    output logic                   result_valid,
    input  wire logic              result_stall,
    output out_word_t              result
);

    localparam int SUM_W = ((TIME_WIDTH > CNT32_W) ? TIME_WIDTH : CNT32_W) + 1;

    // Architectural state.
    logic [TIME_WIDTH-1:0] bank_reg, bank_next;
    logic [CAP_W-1:0]      steps_reg, steps_next;
    logic [CNT32_W-1:0]    disc_reg, disc_next;
    logic [CNT32_W-1:0]    total_reg, total_next;

    // Captured word and per-word flags.
    logic                  kind_reg;
    logic [FT_W-1:0]       ft_reg;
    logic                  taken_reg, taken_next;
    logic                  full_reg, full_next;

    // Divider.
    logic [STEP_W-1:0]     rem_reg, rem_next;
    logic [TIME_WIDTH-1:0] src_reg, src_next;
    logic [FRAC_BITS-1:0]  quo_reg, quo_next;
    logic [STEP_W:0]       rem_shift;
    logic                  rem_ge;

    // Result register.
    logic                  out_valid_reg, out_valid_next;
    out_word_t             out_reg;

    logic [TIME_WIDTH:0]   bank_sum;
    logic [TIME_WIDTH-1:0] step_wide;
    logic [TIME_WIDTH-1:0] drop;
    logic [SUM_W-1:0]      disc_sum;
    logic                  bank_ge;

    assign step_wide = TIME_WIDTH'(step_eff);
    assign bank_ge   = bank_reg >= step_wide;
    assign bank_sum  = {1'b0, bank_reg} + (TIME_WIDTH + 1)'(ft_reg);
    assign drop      = bank_reg - TIME_WIDTH'(rem_reg);
    assign disc_sum  = SUM_W'(disc_reg) + SUM_W'(drop);

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    assign rem_shift = {rem_reg, src_reg[TIME_WIDTH-1]};
    assign rem_ge    = rem_shift >= {1'b0, step_eff};

    assign stat.kind_step    = kind_reg == KIND_STEP;
    assign stat.bank_ge_step = bank_ge;
    assign stat.cap_hit      = steps_reg >= cap_eff;
    assign stat.out_free     = !out_valid_reg || !result_stall;

    always_comb
    begin
        bank_next  = bank_reg;
        steps_next = steps_reg;
        disc_next  = disc_reg;
        total_next = total_reg;
        taken_next = taken_reg;
        full_next  = full_reg;
        rem_next   = rem_reg;
        src_next   = src_reg;
        quo_next   = quo_reg;

        if (cmd.capture)
        begin
            taken_next = 1'b0;
        end

        if (cmd.apply)
        begin
            if (kind_reg == KIND_FRAME)
            begin
                bank_next  = bank_sum[TIME_WIDTH] ? '1 : bank_sum[TIME_WIDTH-1:0];
                steps_next = '0;
                disc_next  = '0;
            end
            else if (bank_ge && !stat.cap_hit)
            begin
                bank_next  = bank_reg - step_wide;
                steps_next = steps_reg + 1'b1;
                total_next = total_reg + 1'b1;
                taken_next = 1'b1;
            end
        end

        if (cmd.mod_start)
        begin
            rem_next = '0;
            src_next = bank_reg;
        end

        if (cmd.mod_commit)
        begin
            bank_next = TIME_WIDTH'(rem_reg);
            disc_next = (disc_sum[SUM_W-1:CNT32_W] != '0) ? CNT32_MAX
                                                          : disc_sum[CNT32_W-1:0];
        end

        if (cmd.frac_start)
        begin
            // The bank is below one step here, so it fits the remainder.
            rem_next  = bank_reg[STEP_W-1:0];
            src_next  = '0;
            full_next = 1'b0;
        end

        if (cmd.alpha_one)
        begin
            full_next = 1'b1;
        end

        if (cmd.div_step)
        begin
            rem_next = rem_ge ? STEP_W'(rem_shift - {1'b0, step_eff})
                              : rem_shift[STEP_W-1:0];
            src_next = {src_reg[TIME_WIDTH-2:0], 1'b0};
            quo_next = {quo_reg[FRAC_BITS-2:0], rem_ge};
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_reg      <= '0;
            steps_reg     <= '0;
            disc_reg      <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            bank_reg      <= bank_next;
            steps_reg     <= steps_next;
            disc_reg      <= disc_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg <= item.kind;
            ft_reg   <= item.frame_time;
        end
        taken_reg <= taken_next;
        full_reg  <= full_next;
        rem_reg   <= rem_next;
        src_reg   <= src_next;
        quo_reg   <= quo_next;
        if (cmd.out_load)
        begin
            out_reg.step_taken   <= taken_reg;
            out_reg.alpha        <= full_reg ? ALPHA_ONE : {1'b0, quo_reg};
            out_reg.frame_steps  <= steps_reg;
            out_reg.dropped_time <= disc_reg;
            out_reg.step_total   <= total_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    `FTA_ASSERT(a_rem_below_step, clk, rst_n,
        !cmd.mod_commit || (rem_reg < step_eff),
        "remainder not below the step length at commit")
    `FTA_ASSERT(a_taken_counts, clk, rst_n,
        !(result_valid && result.step_taken) || (result.frame_steps != '0),
        "granted step not counted in the frame")
    `FTA_ASSERT(a_drop_no_grant, clk, rst_n,
        !(result_valid && (result.dropped_time != '0)) || !result.step_taken,
        "step granted after time was dropped in the same frame")

endmodule

`default_nettype wire

// ===== sv/fixed_timestep_accumulator_unit.sv =====
// ----------------------------------------------------------------------------
// fixed_timestep_accumulator_unit
// Time bank that turns elapsed frame time into whole fixed simulation steps.
// ----------------------------------------------------------------------------
// Use: a word on the item channel either begins a frame (kind 0, frame_time in
// microseconds is added to the bank, saturating) or asks for the next step
// (kind 1). Every item word yields exactly one word on the result channel with
// the grant flag, alpha in Q1.16, the frame step count, the dropped time and
// the running step total. Both channels move a word when valid is high and
// stall is low. Step length and step cap are written over the APB port; the
// user must do so only while the block is idle, as the block does not enforce
// it. Out-of-range values are clamped where they are used. Timing: a word is
// taken only while the sequencer is idle. Alpha comes from a restoring divider
// that yields one quotient bit per cycle. The next word can be taken in the
// first cycle that a result is offered. When the bank holds at least one step
// alpha is 1.0 and the alpha division is skipped. When the step cap is reached
// the divider first works out the bank modulo the step length, one dividend bit
// per cycle. A finished result waits in an output register; while the receiver
// stalls, the next item word is still taken and processed, and that word's
// result waits until the register is free. Reset empties the bank, clears all
// counters and restores step length 16667 and cap 5.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_timestep_accumulator_unit
    import fta_pkg::*;
#(
    parameter int TIME_WIDTH = 32
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,

    input  wire logic              item_valid,
    output logic                   item_stall,
    input  wire in_word_t          item,

    output logic                   result_valid,
    input  wire logic              result_stall,
    output out_word_t              result,

    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0]      prdata,
    output logic                   pready
);

    logic [STEP_W-1:0] step_length_reg;
    logic [CAP_W-1:0]  max_steps_reg;
    logic [STEP_W-1:0] step_eff;
    logic [CAP_W-1:0]  cap_eff;
    logic              cfg_write;
    dp_cmd_t           cmd;
    dp_stat_t          stat;

    // Registers sit at byte addresses 0 and 4; bit 2 picks one.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_length_reg <= STEP_RESET;
            max_steps_reg   <= CAP_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                REG_STEP_LENGTH: step_length_reg <= pwdata[STEP_W-1:0];
                REG_MAX_STEPS:   max_steps_reg   <= pwdata[CAP_W-1:0];
                default:         step_length_reg <= step_length_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_STEP_LENGTH: prdata = DATA_W'(step_length_reg);
            REG_MAX_STEPS:   prdata = DATA_W'(max_steps_reg);
            default:         prdata = '0;
        endcase
    end

    // The registers keep what was written; the clamped values drive the logic.
    always_comb
    begin
        if (step_length_reg < STEP_MIN)
        begin
            step_eff = STEP_MIN;
        end
        else if (step_length_reg > STEP_MAX)
        begin
            step_eff = STEP_MAX;
        end
        else
        begin
            step_eff = step_length_reg;
        end
    end

    // A cap of zero behaves as a cap of one.
    assign cap_eff = (max_steps_reg == '0) ? CAP_ONE : max_steps_reg;

    fta_ctrl #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .stat       (stat),
        .cmd        (cmd)
    );

    fta_dp #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .step_eff     (step_eff),
        .cap_eff      (cap_eff),
        .cmd          (cmd),
        .stat         (stat),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

`default_nettype wire

// ===== dv/fta_result_checker.sv =====
// ----------------------------------------------------------------------------
// fta_result_checker
// Watches the item, result and register ports of the time bank, predicts each
// result word from its own copy of the bank state and compares it field by
// field with what the block delivers.
// ----------------------------------------------------------------------------
module fta_result_checker
    import fta_pkg::*;
#(
    parameter int TIME_WIDTH = 32
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,

    input  wire logic              item_valid,
    input  wire logic              item_stall,
    input  wire in_word_t          item,

    input  wire logic              result_valid,
    input  wire logic              result_stall,
    input  wire out_word_t         result,

    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    input  wire logic [DATA_W-1:0] prdata,
    input  wire logic              pready,

    output int                     mismatches,
    output int                     outstanding
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] BANK_TOP    = (64'd1 << TIME_WIDTH) - 64'd1;
    localparam int          MAX_PRINTED = 200;

    // Shadow registers and bank state.
    logic [STEP_W-1:0]  step_reg;
    logic [CAP_W-1:0]   cap_reg;
    logic [63:0]        bank;
    logic [CAP_W-1:0]   frame_grants;
    logic [CNT32_W-1:0] drop_sum;
    logic [CNT32_W-1:0] grant_count;

    out_word_t          pending_results[$];
    out_word_t          oldest;
    int                 results_seen;

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("%0t: result word %0d: %s", $time, results_seen, msg);
    endtask

    // Applies one item word to the bank and returns the result it must cause.
    function automatic out_word_t advance_bank(input in_word_t w);
        logic [63:0] step_us;
        logic [63:0] cap_eff;
        logic [63:0] room;
        logic [63:0] whole;
        out_word_t   r;
        step_us = 64'(step_reg);
        if (step_us < STEP_MIN)
            step_us = 64'(STEP_MIN);
        else if (step_us > STEP_MAX)
            step_us = 64'(STEP_MAX);
        cap_eff = 64'((cap_reg == '0) ? CAP_ONE : cap_reg);
        r = '0;
        if (w.kind == KIND_FRAME) begin
            room = BANK_TOP - bank;
            bank = (64'(w.frame_time) > room) ? BANK_TOP : bank + 64'(w.frame_time);
            frame_grants = '0;
            drop_sum = '0;
        end
        else if (bank >= step_us) begin
            if (frame_grants >= cap_eff) begin
                // Cap reached: every whole step still banked is thrown away.
                whole = (bank / step_us) * step_us;
                room = 64'(CNT32_MAX - drop_sum);
                bank = bank % step_us;
                drop_sum = (whole > room) ? CNT32_MAX : drop_sum + whole[CNT32_W-1:0];
            end
            else begin
                bank = bank - step_us;
                frame_grants = frame_grants + 1'b1;
                grant_count = grant_count + 1'b1;
                r.step_taken = 1'b1;
            end
        end
        r.alpha = (bank >= step_us) ? ALPHA_ONE : ALPHA_W'((bank << FRAC_BITS) / step_us);
        r.frame_steps = frame_grants;
        r.dropped_time = drop_sum;
        r.step_total = grant_count;
        return r;
    endfunction

    task automatic compare_fields(input out_word_t want, input out_word_t got);
        if (got.step_taken !== want.step_taken)
            report_mismatch($sformatf("step_taken expected %0d, got %0d",
                                      want.step_taken, got.step_taken));
        if (got.alpha !== want.alpha)
            report_mismatch($sformatf("alpha expected %0d, got %0d", want.alpha, got.alpha));
        if (got.frame_steps !== want.frame_steps)
            report_mismatch($sformatf("frame_steps expected %0d, got %0d",
                                      want.frame_steps, got.frame_steps));
        if (got.dropped_time !== want.dropped_time)
            report_mismatch($sformatf("dropped_time expected %0d, got %0d",
                                      want.dropped_time, got.dropped_time));
        if (got.step_total !== want.step_total)
            report_mismatch($sformatf("step_total expected %0d, got %0d",
                                      want.step_total, got.step_total));
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            step_reg = STEP_RESET;
            cap_reg = CAP_RESET;
            bank = '0;
            frame_grants = '0;
            drop_sum = '0;
            grant_count = '0;
            pending_results.delete();
            results_seen = 0;
            mismatches = 0;
            outstanding <= 0;
        end
        else begin
            if (psel && penable && pready) begin
                if (pwrite) begin
                    if (paddr[2] == REG_STEP_LENGTH)
                        step_reg = pwdata[STEP_W-1:0];
                    else
                        cap_reg = pwdata[CAP_W-1:0];
                end
                else if (paddr[2] == REG_STEP_LENGTH) begin
                    if (prdata[STEP_W-1:0] !== step_reg)
                        report_mismatch($sformatf("step_length read %0d, expected %0d",
                                                  prdata[STEP_W-1:0], step_reg));
                end
                else if (prdata[CAP_W-1:0] !== cap_reg)
                    report_mismatch($sformatf("max_steps read %0d, expected %0d",
                                              prdata[CAP_W-1:0], cap_reg));
            end

            // The result is matched before this edge's item is predicted, so a
            // stray result can never pair with a word taken at the same edge.
            if (result_valid && !result_stall) begin
                if (pending_results.size() == 0)
                    report_mismatch("result word with no item waiting for it");
                else begin
                    oldest = pending_results.pop_front();
                    compare_fields(oldest, result);
                end
                results_seen++;
            end

            if (item_valid && !item_stall)
                pending_results.push_back(advance_bank(item));

            outstanding <= pending_results.size();
        end
    end

endmodule

// ===== dv/tb_fixed_timestep_accumulator_unit.sv =====
// ----------------------------------------------------------------------------
// tb_fixed_timestep_accumulator_unit
// Stimulus and verdict for the fixed timestep accumulator. A directed run
// covers the bank edges under the reset timing, then a series of register
// settings, the clamped extremes among them, each carries frames followed by
// step requests with random content. The checker beside the block predicts
// and compares every result word.
// ----------------------------------------------------------------------------
module tb_fixed_timestep_accumulator_unit
    import fta_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int                 TIME_WIDTH    = 32;
    localparam int unsigned        WORD_TARGET   = 850;
    localparam int unsigned        HOLD_CYCLES   = 400;
    localparam int unsigned        END_CYCLES    = 80;
    localparam int unsigned        RUN_LIMIT_NS  = 6_000_000;
    localparam logic [FT_W-1:0]    FT_MAX        = '1;
    localparam logic [ADDR_W-1:0]  ADDR_STEP_LEN = {REG_STEP_LENGTH, 2'b00};
    localparam logic [ADDR_W-1:0]  ADDR_MAX_STEP = {REG_MAX_STEPS, 2'b00};

    logic              clk;
    logic              rst_n;

    logic              item_valid;
    logic              item_stall;
    in_word_t          item;

    logic              result_valid;
    logic              result_stall;
    out_word_t         result;

    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int                mismatches;
    int                outstanding;

    // Stimulus shaping: the effective step length and cap currently in force,
    // so that frame times can be chosen around whole multiples of a step.
    int unsigned       step_eff;
    int unsigned       cap_eff;
    int unsigned       words_sent;

    // Flags from the stimulus to the receiver: no random stalls at all, and a
    // request for one long hold-off.
    logic              quiet_mode;
    logic              hold_req;

    fixed_timestep_accumulator_unit #(
        .TIME_WIDTH(TIME_WIDTH)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .item        (item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result      (result),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    fta_result_checker #(
        .TIME_WIDTH(TIME_WIDTH)
    ) i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .item        (item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result      (result),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // The run is cut off after a generous fixed time in case the block hangs.
    initial begin
        #(RUN_LIMIT_NS);
        $display("RESULT: ERROR");
        $finish;
    end

    // Receiver. In normal running it stalls in about one cycle out of eight.
    // On request it holds off for a long stretch, counted here, so that the
    // output register fills, the word behind it finishes and the block has to
    // stall its item channel.
    initial begin : receiver
        int unsigned hold_count;
        result_stall = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                hold_req <= 1'b0;
                result_stall <= 1'b1;
                for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++)
                    @(posedge clk);
                result_stall <= 1'b0;
            end
            else
                result_stall <= !quiet_mode && ($urandom_range(0, 99) < 12);
        end
    end

    // All bus tasks below are entered right after a rising edge and return
    // right after one, so every input gets at most one update per edge.

    // One APB access: setup cycle, then access cycle until pready, then an
    // idle cycle so back-to-back calls never touch psel twice in one step.
    task automatic apb_access(input logic wr, input logic [ADDR_W-1:0] addr,
                              input logic [DATA_W-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    // Writes both registers, reads them back for the checker, and records the
    // values that the block will actually use after its clamping.
    task automatic set_timing(input logic [DATA_W-1:0] step_word,
                              input logic [DATA_W-1:0] cap_word);
        apb_access(1'b1, ADDR_STEP_LEN, step_word);
        apb_access(1'b1, ADDR_MAX_STEP, cap_word);
        apb_access(1'b0, ADDR_STEP_LEN, $urandom);
        apb_access(1'b0, ADDR_MAX_STEP, $urandom);
        step_eff = 32'(step_word[STEP_W-1:0]);
        if (step_eff < STEP_MIN)
            step_eff = 32'(STEP_MIN);
        else if (step_eff > STEP_MAX)
            step_eff = 32'(STEP_MAX);
        cap_eff = 32'((cap_word[CAP_W-1:0] == '0) ? CAP_ONE : cap_word[CAP_W-1:0]);
    endtask

    // Offers one item word and waits for the edge that takes it. With no
    // random gap, valid simply stays high into the next word.
    task automatic offer_word(input logic word_kind, input logic [FT_W-1:0] ft);
        if (!quiet_mode && $urandom_range(0, 99) < 12) begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 24)) @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= {word_kind, ft};
        do @(posedge clk); while (item_stall);
        words_sent++;
    endtask

    task automatic send_frame(input logic [FT_W-1:0] ft);
        offer_word(KIND_FRAME, ft);
    endtask

    // A step request carries random frame time bits, which it must ignore.
    task automatic send_step();
        offer_word(KIND_STEP, FT_W'($urandom));
    endtask

    // Sender pause: drops valid and waits until every expected result word
    // has arrived, which also leaves the block idle for register writes.
    task automatic drain_results();
        item_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (2) @(posedge clk);
    endtask

    // Mostly a few whole steps plus a random remainder, so that the cap and
    // the drop path are reached; now and then any 24-bit value or an extreme.
    function automatic logic [FT_W-1:0] pick_frame_time();
        logic [63:0] t;
        case ($urandom_range(0, 9))
            0:       t = 64'($urandom & FT_MAX);
            1:       t = $urandom_range(0, 1) ? 64'(FT_MAX) : '0;
            default: t = 64'(step_eff) * $urandom_range(0, ((cap_eff < 6) ? cap_eff : 6) + 2)
                         + 64'($urandom_range(0, step_eff - 1));
        endcase
        if (t > FT_MAX)
            t = 64'(FT_MAX);
        return t[FT_W-1:0];
    endfunction

    // Well-formed frames, each followed by a run of step requests that may go
    // past the cap, mixed with stray steps and arbitrary frames as noise.
    task automatic run_frames(input int unsigned n_words);
        int unsigned target;
        int unsigned steps;
        target = words_sent + n_words;
        while (words_sent < target) begin
            if ($urandom_range(0, 9) == 0) begin
                if ($urandom_range(0, 1))
                    send_step();
                else
                    send_frame(FT_W'($urandom));
            end
            else begin
                send_frame(pick_frame_time());
                steps = $urandom_range(0, ((cap_eff < 10) ? cap_eff : 10) + 3);
                repeat (steps) send_step();
            end
        end
    endtask

    initial begin : stimulus
        logic [DATA_W-1:0] step_word;
        logic [DATA_W-1:0] cap_word;

        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        quiet_mode = 1'b0;
        hold_req = 1'b0;
        step_eff = 32'(STEP_RESET);
        cap_eff = 32'(CAP_RESET);
        words_sent = 0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under the reset timing (step 16667 us, cap 5). A step
        // request on an empty bank grants nothing and reports alpha zero.
        send_step();
        send_frame('0);
        // One microsecond short of a step gives a truncated fraction, and the
        // next microsecond makes the bank exactly one step, so alpha is 1.0.
        send_frame(FT_W'(STEP_RESET - 1'b1));
        send_frame(24'd1);
        send_step();
        send_step();
        // A full frame holds about a thousand steps: five grants, then the
        // cap drops all whole steps, then the leftover is below one step.
        send_frame(FT_MAX);
        repeat (6) send_step();
        send_step();
        send_frame(FT_W'(3 * STEP_RESET - 1));
        repeat (4) send_step();
        send_frame(24'd12345);
        send_step();
        drain_results();

        // Shortest step with a cap of one: the drop path comes up constantly.
        set_timing(32'(STEP_MIN), 32'(CAP_ONE));
        run_frames(60);
        drain_results();

        // Longest step and the largest cap. Enough full frames saturate the
        // bank at its top, then the requests run the frame count up to 255
        // and past it into one large drop.
        set_timing(32'(STEP_MAX), 32'd255);
        repeat (260) send_frame(FT_MAX);
        repeat (258) send_step();
        drain_results();

        // Zero step length and zero cap clamp to the minimum and to one. The
        // receiver holds off for a long stretch while words keep coming.
        set_timing('0, '0);
        hold_req <= 1'b1;
        run_frames(50);
        drain_results();

        // Just below the legal step length, with no idling on either side.
        quiet_mode <= 1'b1;
        set_timing(32'd999, 32'd2);
        run_frames(40);
        drain_results();
        quiet_mode <= 1'b0;

        // Just above the legal range, then the largest 20-bit value with junk
        // in the upper data bits.
        set_timing(32'd1000001, 32'd3);
        run_frames(40);
        drain_results();

        step_word = $urandom;
        step_word[STEP_W-1:0] = '1;
        cap_word = $urandom;
        cap_word[CAP_W-1:0] = 8'd7;
        set_timing(step_word, cap_word);
        run_frames(40);
        drain_results();

        // Random settings until the word budget is used up. The step length
        // stays in the legal range most of the time; the cap stays small most
        // of the time so that it is actually hit.
        while (words_sent < WORD_TARGET) begin
            step_word = $urandom;
            if ($urandom_range(0, 4) != 0)
                step_word[STEP_W-1:0] = STEP_W'($urandom_range(STEP_MIN, STEP_MAX));
            cap_word = $urandom;
            if ($urandom_range(0, 3) != 0)
                cap_word[CAP_W-1:0] = CAP_W'($urandom_range(1, 12));
            set_timing(step_word, cap_word);
            run_frames(40);
            drain_results();
        end

        // Keep the clock running so that a stray late result word is still seen.
        repeat (END_CYCLES) @(posedge clk);

        if (mismatches == 0 && outstanding == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
